// ===== hdl/bqe_pkg.sv =====
// ----------------------------------------------------------------------------
// bqe_pkg
// shared types, register codes and arithmetic helpers of the billboard quad
// expander
// ----------------------------------------------------------------------------
package bqe_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UP_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UP_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UP_Z    = 3'd5;

  // reset values, Q2.14
  localparam logic signed [15:0] RIGHT_X_RST = 16'sd16384;
  localparam logic signed [15:0] RIGHT_Y_RST = 16'sd0;
  localparam logic signed [15:0] RIGHT_Z_RST = 16'sd0;
  localparam logic signed [15:0] UP_X_RST    = 16'sd0;
  localparam logic signed [15:0] UP_Y_RST    = 16'sd16384;
  localparam logic signed [15:0] UP_Z_RST    = 16'sd0;

  // vertex counter, six vertices per particle
  localparam int VERT_CNT_W = 3;
  localparam logic [VERT_CNT_W-1:0] LAST_VERT = 3'd5;

  typedef struct packed {
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
  } cam_t;

  // particle as it arrives
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [15:0]        tex_extent;
    logic [15:0]        tex_layer;
    logic [15:0]        quad_size;
    logic [16:0]        color_r;
    logic [16:0]        color_g;
    logic [16:0]        color_b;
    logic [16:0]        color_a;
  } in_t;

  // particle with quantized color
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [15:0]        tex_extent;
    logic [15:0]        tex_layer;
    logic [15:0]        quad_size;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
  } particle_t;

  // particle with camera vectors scaled by size, units of 2^-23
  typedef struct packed {
    particle_t          p;
    logic signed [32:0] rx_s;
    logic signed [32:0] ry_s;
    logic signed [32:0] rz_s;
    logic signed [32:0] ux_s;
    logic signed [32:0] uy_s;
    logic signed [32:0] uz_s;
  } prod_t;

  // one vertex request from the corner sequencer
  typedef struct packed {
    prod_t q;
    logic  lx_pos;
    logic  ly_pos;
    logic  last;
  } corner_t;

  // output word
  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic [16:0]        vert_u;
    logic [16:0]        vert_v;
    logic [15:0]        vert_layer;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic [15:0]        vert_size;
    logic               last;
  } vert_t;

  // floor(c * 255 / 65536), clamped to a byte
  function automatic logic [7:0] color_byte(input logic [16:0] c);
    logic [24:0] scaled;
    logic [8:0]  q;
    scaled = {c, 8'b0} - {8'b0, c};
    q = scaled[24:16];
    color_byte = (q > 9'd255) ? 8'hFF : q[7:0];
  endfunction

  // Q2.14 vector component times Q8.8 size
  function automatic logic signed [32:0] scale_vec(input logic signed [15:0] v,
                                                   input logic [15:0] s);
    logic signed [16:0] s_ext;
    s_ext = $signed({1'b0, s});
    scale_vec = 33'(v * s_ext);
  endfunction

  // corner order 0,1,2,0,2,3: right side on corners 1 and 2
  function automatic logic corner_lx(input logic [VERT_CNT_W-1:0] k);
    corner_lx = (k == 3'd1) || (k == 3'd2) || (k == 3'd4);
  endfunction

  // up side on corners 2 and 3
  function automatic logic corner_ly(input logic [VERT_CNT_W-1:0] k);
    corner_ly = (k == 3'd2) || (k == 3'd4) || (k == 3'd5);
  endfunction

  // exact vertex coordinate in units of 2^-23
  function automatic logic signed [39:0] vertex_total(input logic signed [31:0] pos,
                                                      input logic signed [32:0] a,
                                                      input logic signed [32:0] b,
                                                      input logic lx, input logic ly);
    logic signed [39:0] pos_w;
    logic signed [39:0] a_w;
    logic signed [39:0] b_w;
    pos_w = {pos[31], pos, 7'b0};
    a_w = 40'(a);
    b_w = 40'(b);
    vertex_total = pos_w + (lx ? a_w : -a_w) + (ly ? b_w : -b_w);
  endfunction

  // round to Q16.16, ties up, then saturate to 32 bits
  function automatic logic signed [31:0] round_sat(input logic signed [39:0] t);
    logic signed [39:0] biased;
    logic signed [32:0] r;
    biased = t + 40'sd64;
    r = biased[39:7];
    if (r[32] != r[31]) begin
      round_sat = r[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      round_sat = r[31:0];
    end
  endfunction

endpackage

// ===== hdl/bqe_front.sv =====
// ----------------------------------------------------------------------------
// bqe_front
// input register with color quantize, then the size multiply stage
// ----------------------------------------------------------------------------
module bqe_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  bqe_pkg::in_t     in_part,
  input  bqe_pkg::cam_t    cam,
  output logic             prod_valid,
  input  logic             prod_ready,
  output bqe_pkg::prod_t   prod
);
  import bqe_pkg::*;

  logic      s1_valid;
  particle_t s1;
  logic      s1_adv;
  logic      s2_adv;

  assign s2_adv   = !prod_valid || prod_ready;
  assign s1_adv   = !s1_valid || s2_adv;
  assign in_ready = s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      if (s1_adv) s1_valid <= in_valid;
      if (s2_adv) prod_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1.pos_x      <= in_part.pos_x;
      s1.pos_y      <= in_part.pos_y;
      s1.pos_z      <= in_part.pos_z;
      s1.tex_u      <= in_part.tex_u;
      s1.tex_v      <= in_part.tex_v;
      s1.tex_extent <= in_part.tex_extent;
      s1.tex_layer  <= in_part.tex_layer;
      s1.quad_size  <= in_part.quad_size;
      s1.red        <= color_byte(in_part.color_r);
      s1.green      <= color_byte(in_part.color_g);
      s1.blue       <= color_byte(in_part.color_b);
      s1.alpha      <= color_byte(in_part.color_a);
    end
    if (s2_adv && s1_valid) begin
      prod.p    <= s1;
      prod.rx_s <= scale_vec(cam.right_x, s1.quad_size);
      prod.ry_s <= scale_vec(cam.right_y, s1.quad_size);
      prod.rz_s <= scale_vec(cam.right_z, s1.quad_size);
      prod.ux_s <= scale_vec(cam.up_x, s1.quad_size);
      prod.uy_s <= scale_vec(cam.up_y, s1.quad_size);
      prod.uz_s <= scale_vec(cam.up_z, s1.quad_size);
    end
  end

endmodule

// ===== hdl/bqe_corner.sv =====
// ----------------------------------------------------------------------------
// bqe_corner
// holds one particle and walks its six vertices, one vertex per cycle while v_ready is high
// ----------------------------------------------------------------------------
module bqe_corner (
  input  logic              clk,
  input  logic              rst,
  input  logic              prod_valid,
  output logic              prod_ready,
  input  bqe_pkg::prod_t    prod,
  output logic              v_valid,
  input  logic              v_ready,
  output bqe_pkg::corner_t  v_item
);
  import bqe_pkg::*;

  logic                  cur_valid;
  prod_t                 cur;
  logic [VERT_CNT_W-1:0] k;
  logic                  fire;

  assign fire       = cur_valid && v_ready;
  // next particle loads as the sixth vertex leaves
  assign prod_ready = !cur_valid || (v_ready && (k == LAST_VERT));

  assign v_valid       = cur_valid;
  assign v_item.q      = cur;
  assign v_item.lx_pos = corner_lx(k);
  assign v_item.ly_pos = corner_ly(k);
  assign v_item.last   = (k == LAST_VERT);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      k         <= '0;
    end else if (prod_ready) begin
      cur_valid <= prod_valid;
      k         <= '0;
    end else if (fire) begin
      k <= k + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && prod_valid) cur <= prod;
  end

endmodule

// ===== hdl/bqe_vertex.sv =====
// ----------------------------------------------------------------------------
// bqe_vertex
// corner offset sum stage, then round and saturate into the output register
// ----------------------------------------------------------------------------
module bqe_vertex (
  input  logic              clk,
  input  logic              rst,
  input  logic              v_valid,
  output logic              v_ready,
  input  bqe_pkg::corner_t  v_item,
  output logic              out_valid,
  input  logic              out_ready,
  output bqe_pkg::vert_t    vert
);
  import bqe_pkg::*;

  typedef struct packed {
    logic signed [39:0] tot_x;
    logic signed [39:0] tot_y;
    logic signed [39:0] tot_z;
    logic [16:0]        vert_u;
    logic [16:0]        vert_v;
    logic [15:0]        vert_layer;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic [15:0]        vert_size;
    logic               last;
  } sum_t;

  logic s3_valid;
  sum_t s3;
  logic s3_adv;
  logic s4_adv;

  assign s4_adv  = !out_valid || out_ready;
  assign s3_adv  = !s3_valid || s4_adv;
  assign v_ready = s3_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s3_adv) s3_valid <= v_valid;
      if (s4_adv) out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv && v_valid) begin
      s3.tot_x <= vertex_total(v_item.q.p.pos_x, v_item.q.rx_s, v_item.q.ux_s,
                               v_item.lx_pos, v_item.ly_pos);
      s3.tot_y <= vertex_total(v_item.q.p.pos_y, v_item.q.ry_s, v_item.q.uy_s,
                               v_item.lx_pos, v_item.ly_pos);
      s3.tot_z <= vertex_total(v_item.q.p.pos_z, v_item.q.rz_s, v_item.q.uz_s,
                               v_item.lx_pos, v_item.ly_pos);
      s3.vert_u <= {1'b0, v_item.q.p.tex_u}
                   + (v_item.lx_pos ? {1'b0, v_item.q.p.tex_extent} : 17'd0);
      s3.vert_v <= {1'b0, v_item.q.p.tex_v}
                   + (v_item.ly_pos ? {1'b0, v_item.q.p.tex_extent} : 17'd0);
      s3.vert_layer <= v_item.q.p.tex_layer;
      s3.red        <= v_item.q.p.red;
      s3.green      <= v_item.q.p.green;
      s3.blue       <= v_item.q.p.blue;
      s3.alpha      <= v_item.q.p.alpha;
      s3.vert_size  <= v_item.q.p.quad_size;
      s3.last       <= v_item.last;
    end
    if (s4_adv && s3_valid) begin
      vert.vert_x     <= round_sat(s3.tot_x);
      vert.vert_y     <= round_sat(s3.tot_y);
      vert.vert_z     <= round_sat(s3.tot_z);
      vert.vert_u     <= s3.vert_u;
      vert.vert_v     <= s3.vert_v;
      vert.vert_layer <= s3.vert_layer;
      vert.red        <= s3.red;
      vert.green      <= s3.green;
      vert.blue       <= s3.blue;
      vert.alpha      <= s3.alpha;
      vert.vert_size  <= s3.vert_size;
      vert.last       <= s3.last;
    end
  end

endmodule

// ===== hdl/billboard_quad_expand_unit.sv =====
// pipeline: a particle word passes the input register and the size product register
// into the corner sequencer; each vertex word then passes the offset sum register
// and the output register. The corner sequencer issues one vertex word per cycle,
// while the output does not stall, into the single output channel
// reset: synchronous, clears all valid bits and loads the camera vectors with
// right = (1,0,0) and up = (0,1,0)
// ----------------------------------------------------------------------------
// billboard_quad_expand_unit
// expands one particle into six vertex words of a camera-facing quad
// ----------------------------------------------------------------------------
module billboard_quad_expand_unit (
  input  logic                              clk,
  input  logic                              rst,
  // particle input
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [31:0]                pos_x,
  input  logic signed [31:0]                pos_y,
  input  logic signed [31:0]                pos_z,
  input  logic [15:0]                       tex_u,
  input  logic [15:0]                       tex_v,
  input  logic [15:0]                       tex_extent,
  input  logic [15:0]                       tex_layer,
  input  logic [15:0]                       quad_size,
  input  logic [16:0]                       color_r,
  input  logic [16:0]                       color_g,
  input  logic [16:0]                       color_b,
  input  logic [16:0]                       color_a,
  // vertex output
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [31:0]                vert_x,
  output logic signed [31:0]                vert_y,
  output logic signed [31:0]                vert_z,
  output logic [16:0]                       vert_u,
  output logic [16:0]                       vert_v,
  output logic [15:0]                       vert_layer,
  output logic [7:0]                        red,
  output logic [7:0]                        green,
  output logic [7:0]                        blue,
  output logic [7:0]                        alpha,
  output logic [15:0]                       vert_size,
  output logic                              last,
  // camera vector writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bqe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                       cfg_data
);
  import bqe_pkg::*;

  cam_t    cam;
  in_t     in_part;
  logic    prod_valid;
  logic    prod_ready;
  prod_t   prod;
  logic    v_valid;
  logic    v_ready;
  corner_t v_item;
  vert_t   vert;

  // configuration writes never stall; indexes past the last register drop
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam.right_x <= RIGHT_X_RST;
      cam.right_y <= RIGHT_Y_RST;
      cam.right_z <= RIGHT_Z_RST;
      cam.up_x    <= UP_X_RST;
      cam.up_y    <= UP_Y_RST;
      cam.up_z    <= UP_Z_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RIGHT_X: cam.right_x <= cfg_data;
        REG_RIGHT_Y: cam.right_y <= cfg_data;
        REG_RIGHT_Z: cam.right_z <= cfg_data;
        REG_UP_X:    cam.up_x    <= cfg_data;
        REG_UP_Y:    cam.up_y    <= cfg_data;
        REG_UP_Z:    cam.up_z    <= cfg_data;
        default: ;
      endcase
    end
  end

  // gather the particle word
  assign in_part.pos_x      = pos_x;
  assign in_part.pos_y      = pos_y;
  assign in_part.pos_z      = pos_z;
  assign in_part.tex_u      = tex_u;
  assign in_part.tex_v      = tex_v;
  assign in_part.tex_extent = tex_extent;
  assign in_part.tex_layer  = tex_layer;
  assign in_part.quad_size  = quad_size;
  assign in_part.color_r    = color_r;
  assign in_part.color_g    = color_g;
  assign in_part.color_b    = color_b;
  assign in_part.color_a    = color_a;

  // stage 1: capture and quantize color, stage 2: right/up times size
  bqe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_part    (in_part),
    .cam        (cam),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod)
  );

  // stage 3: corner walk, six vertex requests per particle
  bqe_corner u_corner (
    .clk        (clk),
    .rst        (rst),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod),
    .v_valid    (v_valid),
    .v_ready    (v_ready),
    .v_item     (v_item)
  );

  // stage 4: exact offset sum, stage 5: round, saturate, output register
  bqe_vertex u_vertex (
    .clk       (clk),
    .rst       (rst),
    .v_valid   (v_valid),
    .v_ready   (v_ready),
    .v_item    (v_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .vert      (vert)
  );

  // scatter the vertex word
  assign vert_x     = vert.vert_x;
  assign vert_y     = vert.vert_y;
  assign vert_z     = vert.vert_z;
  assign vert_u     = vert.vert_u;
  assign vert_v     = vert.vert_v;
  assign vert_layer = vert.vert_layer;
  assign red        = vert.red;
  assign green      = vert.green;
  assign blue       = vert.blue;
  assign alpha      = vert.alpha;
  assign vert_size  = vert.vert_size;
  assign last       = vert.last;

`ifndef ASSERT_OFF
  // an accepted last vertex is never directly followed by another last vertex on the output
  a_out_last_spacing: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> !(out_valid && last))
    else $error("two last vertices in a row on output");

  a_corner_last_spacing: assert property (@(posedge clk) disable iff (rst)
    (v_valid && v_ready && v_item.last) |=> !(v_valid && v_item.last))
    else $error("corner sequencer repeated its last vertex");

  // a stalled vertex request keeps its corner
  a_corner_hold: assert property (@(posedge clk) disable iff (rst)
    (v_valid && !v_ready) |=> (v_valid && $stable(v_item.lx_pos)
                               && $stable(v_item.ly_pos) && $stable(v_item.last)))
    else $error("corner request changed while stalled");
`endif

endmodule
